FILE: rtl/assert_macros.svh
// Assertion macros used by the core RTL file of the drive/turn PID controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, switched off while rst_n is low
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication check on clk: cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/dtpid_pkg.sv
// Package: widths, codes, reset values and transaction types of the drive/turn PID controller
package dtpid_pkg;

    // Field widths
    localparam int GAIN_W    = 16;
    localparam int GOAL_W    = 16;
    localparam int SPD_W     = 7;
    localparam int POS_W     = 24;
    localparam int POWER_W   = 8;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;

    // Datapath widths
    localparam int TE_W       = POS_W + 1;        // heading difference
    localparam int ERR_W      = 27;               // drive error, turn error sign-extended
    localparam int DER_W      = ERR_W + 1;        // error difference
    localparam int MA_W       = GAIN_W + 1;       // multiplier operand a (gain, signed view)
    localparam int MB_W       = DER_W;            // multiplier operand b
    localparam int PROD_W     = MA_W + MB_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int RND_SHIFT  = 8;                // Q8.8 to integer
    localparam int ROUND_HALF = 1 << (RND_SHIFT - 1);
    localparam int CORR_W     = PROD_W - RND_SHIFT;

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DRIVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TURN  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_KP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_KI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_KD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_KP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_KI  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_KD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_KP  = 3'd6;

    // Gain reset values (Q8.8)
    localparam logic [GAIN_W-1:0] DRIVE_KP_RST = 16'd26;
    localparam logic [GAIN_W-1:0] DRIVE_KI_RST = 16'd5;
    localparam logic [GAIN_W-1:0] DRIVE_KD_RST = 16'd8;
    localparam logic [GAIN_W-1:0] TURN_KP_RST  = 16'd95;
    localparam logic [GAIN_W-1:0] TURN_KI_RST  = 16'd3;
    localparam logic [GAIN_W-1:0] TURN_KD_RST  = 16'd38;
    localparam logic [GAIN_W-1:0] HOLD_KP_RST  = 16'd179;

    // Fixed constants
    localparam int COUNTS_PER_UNIT = 820;
    localparam int DRIVE_TOL       = 10;
    localparam int TURN_TOL        = 5;
    localparam int POWER_MAX       = 100;

    // Defaults of the integral clamp parameters
    localparam int DRIVE_INTEGRAL_LIMIT_DEF = 1000;
    localparam int TURN_INTEGRAL_MAX_DEF    = 700;
    localparam int TURN_INTEGRAL_MIN_DEF    = 5;

    // Command transaction
    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [GOAL_W-1:0] goal;
        logic [SPD_W-1:0]         speed_limit;
        logic signed [POS_W-1:0]  left_position;
        logic signed [POS_W-1:0]  right_position;
        logic signed [POS_W-1:0]  heading;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic signed [POWER_W-1:0] left_power;
        logic signed [POWER_W-1:0] right_power;
        logic                      driving;
        logic                      turning;
        logic                      zero_encoders;
        logic                      move_done;
    } out_item_t;

    // Multiply-accumulate control
    typedef struct packed {
        logic load;     // accumulator takes the registered product
        logic add;      // accumulator adds the registered product
    } mac_ctrl_t;

endpackage

FILE: rtl/dtpid_if.sv
// Valid/ready channel interfaces for command and result transactions
interface dtpid_cmd_if;
    logic                 valid;
    logic                 ready;
    dtpid_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dtpid_res_if;
    logic                 valid;
    logic                 ready;
    dtpid_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/drive_turn_pid_controller_core.sv
// Top level: sequencer and state of the two-mode drive/turn PID controller
// From command acceptance to result valid a drive tick runs decode, MUL820, error, P, I, D,
// sum, PID, heading correction, output and finish; a turn tick skips MUL820 and the correction;
// a start command, idle tick or unused mode code goes from decode to finish. A new command is
// taken only in idle; the sequence on the single shared multiplier runs first, and a stalled
// result holds the block in finish longer. Reset: move state and heading reference cleared,
// gains back to their defaults; no clearing pass, the block is ready as soon as reset ends.
`include "assert_macros.svh"

module drive_turn_pid_controller_core #(
    parameter int DRIVE_INTEGRAL_LIMIT = dtpid_pkg::DRIVE_INTEGRAL_LIMIT_DEF,
    parameter int TURN_INTEGRAL_MAX    = dtpid_pkg::TURN_INTEGRAL_MAX_DEF,
    parameter int TURN_INTEGRAL_MIN    = dtpid_pkg::TURN_INTEGRAL_MIN_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    dtpid_cmd_if.sink                             cmd,
    dtpid_res_if.source                           result,
    input  logic                                  cfg_wen,
    input  logic [dtpid_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dtpid_pkg::GAIN_W-1:0]          cfg_wdata
);

    localparam int GAIN_W    = dtpid_pkg::GAIN_W;
    localparam int GOAL_W    = dtpid_pkg::GOAL_W;
    localparam int SPD_W     = dtpid_pkg::SPD_W;
    localparam int POS_W     = dtpid_pkg::POS_W;
    localparam int POWER_W   = dtpid_pkg::POWER_W;
    localparam int TE_W      = dtpid_pkg::TE_W;
    localparam int ERR_W     = dtpid_pkg::ERR_W;
    localparam int DER_W     = dtpid_pkg::DER_W;
    localparam int MA_W      = dtpid_pkg::MA_W;
    localparam int MB_W      = dtpid_pkg::MB_W;
    localparam int PROD_W    = dtpid_pkg::PROD_W;
    localparam int ACC_W     = dtpid_pkg::ACC_W;
    localparam int CORR_W    = dtpid_pkg::CORR_W;
    localparam int RND_SHIFT = dtpid_pkg::RND_SHIFT;
    localparam int SUM_W     = CORR_W + 1;

    // Integral widths follow the clamp parameters
    localparam int DIW   = $clog2(DRIVE_INTEGRAL_LIMIT + 1) + 1;
    localparam int T_TOP = (TURN_INTEGRAL_MAX > TURN_INTEGRAL_MIN) ?
                           TURN_INTEGRAL_MAX : TURN_INTEGRAL_MIN;
    localparam int TIW   = $clog2(T_TOP + 1);

    // Signed constants
    localparam logic signed [DER_W-1:0]   D_LIM_HI  = DER_W'(DRIVE_INTEGRAL_LIMIT);
    localparam logic signed [DER_W-1:0]   D_LIM_LO  = -D_LIM_HI;
    localparam logic signed [DER_W-1:0]   T_INT_MAX = DER_W'(TURN_INTEGRAL_MAX);
    localparam logic signed [DER_W-1:0]   T_INT_MIN = DER_W'(TURN_INTEGRAL_MIN);
    localparam logic signed [MA_W-1:0]    CPU_A     = MA_W'(dtpid_pkg::COUNTS_PER_UNIT);
    localparam logic signed [ERR_W-1:0]   D_TOL     = ERR_W'(dtpid_pkg::DRIVE_TOL);
    localparam logic signed [ERR_W-1:0]   T_TOL     = ERR_W'(dtpid_pkg::TURN_TOL);
    localparam logic signed [SUM_W-1:0]   PMAX_S    = SUM_W'(dtpid_pkg::POWER_MAX);
    localparam logic signed [POWER_W-1:0] PMAX_P    = POWER_W'(dtpid_pkg::POWER_MAX);
    localparam logic [SPD_W-1:0]          SPD_MAX   = SPD_W'(dtpid_pkg::POWER_MAX);
    localparam logic signed [ACC_W-1:0]   ACC_HALF  = ACC_W'(dtpid_pkg::ROUND_HALF);
    localparam logic signed [PROD_W-1:0]  PROD_HALF = PROD_W'(dtpid_pkg::ROUND_HALF);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL820,
        S_ERR,
        S_P,
        S_I,
        S_D,
        S_SUM,
        S_PID,
        S_CORR,
        S_OUT,
        S_FIN
    } state_t;

    // Control and move state
    state_t                    state_reg, state_next;
    logic                      drive_busy_reg, drive_busy_next;
    logic                      turn_busy_reg, turn_busy_next;
    logic                      is_turn_reg, is_turn_next;
    logic signed [GOAL_W-1:0]  target_reg, target_next;
    logic [SPD_W-1:0]          plimit_reg, plimit_next;
    logic signed [DIW-1:0]     dinteg_reg, dinteg_next;
    logic [TIW-1:0]            tinteg_reg, tinteg_next;
    logic signed [ERR_W-1:0]   last_derr_reg, last_derr_next;
    logic signed [TE_W-1:0]    last_terr_reg, last_terr_next;
    logic signed [POS_W-1:0]   href_reg, href_next;
    logic                      res_valid_reg, res_valid_next;

    // Gains
    logic [GAIN_W-1:0]         drive_kp_reg, drive_ki_reg, drive_kd_reg;
    logic [GAIN_W-1:0]         turn_kp_reg, turn_ki_reg, turn_kd_reg, hold_kp_reg;

    // Payload registers
    dtpid_pkg::in_item_t       item_reg, item_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [DER_W-1:0]   der_reg, der_next;
    logic signed [TE_W-1:0]    hdiff_reg, hdiff_next;
    logic signed [POWER_W-1:0] pid_reg, pid_next;
    logic signed [CORR_W-1:0]  corr_reg, corr_next;
    logic signed [POWER_W-1:0] lp_reg, lp_next;
    logic signed [POWER_W-1:0] rp_reg, rp_next;
    logic                      done_reg, done_next;
    dtpid_pkg::out_item_t      res_data_reg, res_data_next;

    // Shared multiplier
    dtpid_pkg::mac_ctrl_t      mac_ctrl;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   acc;

    // Intermediate arithmetic
    logic                      cmd_acc;
    logic                      res_free;
    logic [GAIN_W-1:0]         kp_sel, ki_sel, kd_sel;
    logic signed [POS_W:0]     pos_sum;
    logic signed [POS_W:0]     pos_avg;
    logic signed [ERR_W-1:0]   drive_err;
    logic signed [ERR_W-1:0]   turn_err;
    logic signed [ERR_W-1:0]   last_err;
    logic signed [DER_W-1:0]   dsum;
    logic signed [DER_W-1:0]   tsum;
    logic signed [ACC_W-1:0]   racc;
    logic signed [ACC_W-1:0]   plim_s;
    logic signed [PROD_W-1:0]  rprod;
    logic signed [SUM_W-1:0]   lsum, rsum;
    logic signed [ERR_W-1:0]   tol;
    logic                      in_tol;

    assign cmd_acc  = cmd.valid && cmd.ready;
    assign res_free = !res_valid_reg || result.ready;

    assign cmd.ready     = (state_reg == S_IDLE);
    assign result.valid  = res_valid_reg;
    assign result.data   = res_data_reg;

    // Gain selection by move type
    assign kp_sel = is_turn_reg ? turn_kp_reg : drive_kp_reg;
    assign ki_sel = is_turn_reg ? turn_ki_reg : drive_ki_reg;
    assign kd_sel = is_turn_reg ? turn_kd_reg : drive_kd_reg;

    // Error terms
    assign pos_sum   = (POS_W + 1)'(item_reg.left_position)
                     + (POS_W + 1)'(item_reg.right_position);
    assign pos_avg   = pos_sum >>> 1;
    assign drive_err = $signed(prod[ERR_W-1:0]) - ERR_W'(pos_avg);
    assign turn_err  = ERR_W'(target_reg) - ERR_W'(item_reg.heading);
    assign last_err  = is_turn_reg ? ERR_W'(last_terr_reg) : last_derr_reg;
    assign dsum      = DER_W'(err_reg) + DER_W'(dinteg_reg);
    assign tsum      = DER_W'(err_reg) + DER_W'($signed({1'b0, tinteg_reg}));

    // Rounding and output sums
    assign racc   = (acc + ACC_HALF) >>> RND_SHIFT;
    assign plim_s = ACC_W'($signed({1'b0, plimit_reg}));
    assign rprod  = (prod + PROD_HALF) >>> RND_SHIFT;
    assign lsum   = SUM_W'(pid_reg) - SUM_W'(corr_reg);
    assign rsum   = SUM_W'(pid_reg) + SUM_W'(corr_reg);
    assign tol    = is_turn_reg ? T_TOL : D_TOL;
    assign in_tol = (err_reg <= tol) && (err_reg >= -tol);

    // Multiplier operands and accumulator control by step
    always_comb
    begin
        mul_a         = '0;
        mul_b         = '0;
        mac_ctrl.load = 1'b0;
        mac_ctrl.add  = 1'b0;
        case (state_reg)
            S_MUL820:
            begin
                mul_a = CPU_A;
                mul_b = MB_W'(target_reg);
            end
            S_P:
            begin
                mul_a = $signed({1'b0, kp_sel});
                mul_b = MB_W'(err_reg);
            end
            S_I:
            begin
                mul_a         = $signed({1'b0, ki_sel});
                mul_b         = is_turn_reg ? MB_W'($signed({1'b0, tinteg_reg}))
                                            : MB_W'(dinteg_reg);
                mac_ctrl.load = 1'b1;
            end
            S_D:
            begin
                mul_a        = $signed({1'b0, kd_sel});
                mul_b        = der_reg;
                mac_ctrl.add = 1'b1;
            end
            S_SUM:
            begin
                mac_ctrl.add = 1'b1;
            end
            S_PID:
            begin
                mul_a = $signed({1'b0, hold_kp_reg});
                mul_b = MB_W'(hdiff_reg);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    dtpid_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod),
        .acc  (acc)
    );

    // Sequencer and next-state logic
    always_comb
    begin
        state_next      = state_reg;
        drive_busy_next = drive_busy_reg;
        turn_busy_next  = turn_busy_reg;
        is_turn_next    = is_turn_reg;
        target_next     = target_reg;
        plimit_next     = plimit_reg;
        dinteg_next     = dinteg_reg;
        tinteg_next     = tinteg_reg;
        last_derr_next  = last_derr_reg;
        last_terr_next  = last_terr_reg;
        href_next       = href_reg;
        res_valid_next  = res_valid_reg && !result.ready;
        item_next       = item_reg;
        err_next        = err_reg;
        der_next        = der_reg;
        hdiff_next      = hdiff_reg;
        pid_next        = pid_reg;
        corr_next       = corr_reg;
        lp_next         = lp_reg;
        rp_next         = rp_reg;
        done_next       = done_reg;
        res_data_next   = res_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    item_next  = cmd.data;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                lp_next    = '0;
                rp_next    = '0;
                done_next  = 1'b0;
                hdiff_next = TE_W'(item_reg.heading) - TE_W'(href_reg);
                state_next = S_FIN;
                if ((item_reg.mode == dtpid_pkg::MODE_DRIVE) ||
                    (item_reg.mode == dtpid_pkg::MODE_TURN))
                begin
                    // start command: new target and limit, other move dropped
                    target_next     = item_reg.goal;
                    plimit_next     = (item_reg.speed_limit > SPD_MAX) ? SPD_MAX
                                                                       : item_reg.speed_limit;
                    drive_busy_next = (item_reg.mode == dtpid_pkg::MODE_DRIVE);
                    turn_busy_next  = (item_reg.mode == dtpid_pkg::MODE_TURN);
                end
                else if (item_reg.mode == dtpid_pkg::MODE_TICK)
                begin
                    if (drive_busy_reg)
                    begin
                        is_turn_next = 1'b0;
                        state_next   = S_MUL820;
                    end
                    else if (turn_busy_reg)
                    begin
                        is_turn_next = 1'b1;
                        state_next   = S_ERR;
                    end
                end
            end
            S_MUL820:
            begin
                state_next = S_ERR;
            end
            S_ERR:
            begin
                err_next   = is_turn_reg ? turn_err : drive_err;
                state_next = S_P;
            end
            S_P:
            begin
                // derivative, integral clamp, previous error
                der_next = DER_W'(err_reg) - DER_W'(last_err);
                if (is_turn_reg)
                begin
                    if (tsum >= T_INT_MAX)
                    begin
                        tinteg_next = T_INT_MAX[TIW-1:0];
                    end
                    else if (tsum <= T_INT_MIN)
                    begin
                        tinteg_next = T_INT_MIN[TIW-1:0];
                    end
                    else
                    begin
                        tinteg_next = tsum[TIW-1:0];
                    end
                    last_terr_next = err_reg[TE_W-1:0];
                end
                else
                begin
                    if (dsum > D_LIM_HI)
                    begin
                        dinteg_next = D_LIM_HI[DIW-1:0];
                    end
                    else if (dsum < D_LIM_LO)
                    begin
                        dinteg_next = D_LIM_LO[DIW-1:0];
                    end
                    else
                    begin
                        dinteg_next = dsum[DIW-1:0];
                    end
                    last_derr_next = err_reg;
                end
                state_next = S_I;
            end
            S_I:
            begin
                state_next = S_D;
            end
            S_D:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_PID;
            end
            S_PID:
            begin
                // round the PID sum and clamp to the move's power limit
                if (racc > plim_s)
                begin
                    pid_next = plim_s[POWER_W-1:0];
                end
                else if (racc < -plim_s)
                begin
                    pid_next = -plim_s[POWER_W-1:0];
                end
                else
                begin
                    pid_next = racc[POWER_W-1:0];
                end
                state_next = is_turn_reg ? S_OUT : S_CORR;
            end
            S_CORR:
            begin
                corr_next  = rprod[CORR_W-1:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (is_turn_reg)
                begin
                    lp_next = pid_reg;
                    rp_next = -pid_reg;
                end
                else
                begin
                    // heading hold: left minus, right plus, each saturated
                    if (lsum > PMAX_S)
                    begin
                        lp_next = PMAX_P;
                    end
                    else if (lsum < -PMAX_S)
                    begin
                        lp_next = -PMAX_P;
                    end
                    else
                    begin
                        lp_next = lsum[POWER_W-1:0];
                    end
                    if (rsum > PMAX_S)
                    begin
                        rp_next = PMAX_P;
                    end
                    else if (rsum < -PMAX_S)
                    begin
                        rp_next = -PMAX_P;
                    end
                    else
                    begin
                        rp_next = rsum[POWER_W-1:0];
                    end
                end
                done_next = in_tol;
                if (in_tol)
                begin
                    // move complete: clear move state
                    if (is_turn_reg)
                    begin
                        href_next = POS_W'(target_reg);
                    end
                    drive_busy_next = 1'b0;
                    turn_busy_next  = 1'b0;
                    target_next     = '0;
                    plimit_next     = '0;
                    dinteg_next     = '0;
                    tinteg_next     = '0;
                    last_derr_next  = '0;
                    last_terr_next  = '0;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (res_free)
                begin
                    res_valid_next               = 1'b1;
                    res_data_next.left_power     = lp_reg;
                    res_data_next.right_power    = rp_reg;
                    res_data_next.driving        = drive_busy_reg;
                    res_data_next.turning        = turn_busy_reg;
                    res_data_next.zero_encoders  = done_reg;
                    res_data_next.move_done      = done_reg;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, move state and gains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            drive_busy_reg <= 1'b0;
            turn_busy_reg  <= 1'b0;
            is_turn_reg    <= 1'b0;
            target_reg     <= '0;
            plimit_reg     <= '0;
            dinteg_reg     <= '0;
            tinteg_reg     <= '0;
            last_derr_reg  <= '0;
            last_terr_reg  <= '0;
            href_reg       <= '0;
            res_valid_reg  <= 1'b0;
            drive_kp_reg   <= dtpid_pkg::DRIVE_KP_RST;
            drive_ki_reg   <= dtpid_pkg::DRIVE_KI_RST;
            drive_kd_reg   <= dtpid_pkg::DRIVE_KD_RST;
            turn_kp_reg    <= dtpid_pkg::TURN_KP_RST;
            turn_ki_reg    <= dtpid_pkg::TURN_KI_RST;
            turn_kd_reg    <= dtpid_pkg::TURN_KD_RST;
            hold_kp_reg    <= dtpid_pkg::HOLD_KP_RST;
        end
        else
        begin
            state_reg      <= state_next;
            drive_busy_reg <= drive_busy_next;
            turn_busy_reg  <= turn_busy_next;
            is_turn_reg    <= is_turn_next;
            target_reg     <= target_next;
            plimit_reg     <= plimit_next;
            dinteg_reg     <= dinteg_next;
            tinteg_reg     <= tinteg_next;
            last_derr_reg  <= last_derr_next;
            last_terr_reg  <= last_terr_next;
            href_reg       <= href_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_wen)
            begin
                case (cfg_index)
                    dtpid_pkg::REG_DRIVE_KP: drive_kp_reg <= cfg_wdata;
                    dtpid_pkg::REG_DRIVE_KI: drive_ki_reg <= cfg_wdata;
                    dtpid_pkg::REG_DRIVE_KD: drive_kd_reg <= cfg_wdata;
                    dtpid_pkg::REG_TURN_KP:  turn_kp_reg  <= cfg_wdata;
                    dtpid_pkg::REG_TURN_KI:  turn_ki_reg  <= cfg_wdata;
                    dtpid_pkg::REG_TURN_KD:  turn_kd_reg  <= cfg_wdata;
                    dtpid_pkg::REG_HOLD_KP:  hold_kp_reg  <= cfg_wdata;
                    default:                 hold_kp_reg  <= hold_kp_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        err_reg      <= err_next;
        der_reg      <= der_next;
        hdiff_reg    <= hdiff_next;
        pid_reg      <= pid_next;
        corr_reg     <= corr_next;
        lp_reg       <= lp_next;
        rp_reg       <= rp_next;
        done_reg     <= done_next;
        res_data_reg <= res_data_next;
    end

    // Checks
    `ASSERT_CLK(a_busy_excl, !(drive_busy_reg && turn_busy_reg), "drive and turn both active")
    `ASSERT_CLK(a_dinteg_rng, (DER_W'(dinteg_reg) <= D_LIM_HI) && (DER_W'(dinteg_reg) >= D_LIM_LO), "drive integral outside its clamp")
    `ASSERT_NEXT(a_done_clears, (state_reg == S_OUT) && in_tol, !drive_busy_reg && !turn_busy_reg, "completed move still active")
    `ASSERT_CLK(a_res_power, !res_valid_reg || ((res_data_reg.left_power <= PMAX_P) && (res_data_reg.left_power >= -PMAX_P) && (res_data_reg.right_power <= PMAX_P) && (res_data_reg.right_power >= -PMAX_P)), "motor power out of range")
    `ASSERT_NEXT(a_acc_decode, cmd.valid && cmd.ready, state_reg == S_DECODE, "accepted command not decoded")

endmodule

FILE: rtl/dtpid_mac.sv
// Shared multiplier with registered product and a product accumulator
module dtpid_mac (
    input  logic                                   clk,
    input  dtpid_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [dtpid_pkg::MA_W-1:0]      op_a,
    input  logic signed [dtpid_pkg::MB_W-1:0]      op_b,
    output logic signed [dtpid_pkg::PROD_W-1:0]    prod,
    output logic signed [dtpid_pkg::ACC_W-1:0]     acc
);

    localparam int PROD_W = dtpid_pkg::PROD_W;
    localparam int ACC_W  = dtpid_pkg::ACC_W;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    // Accumulator update
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.load)
        begin
            acc_next = ACC_W'(prod_reg);
        end
        else if (ctrl.add)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    // Product register, then accumulator
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        acc_reg  <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the drive/turn PID controller: directed table, then random moves
`timescale 1ns / 100ps

module testbench;

    // Widths, codes and constants taken from the package
    localparam int MODE_W    = dtpid_pkg::MODE_W;
    localparam int GOAL_W    = dtpid_pkg::GOAL_W;
    localparam int SPD_W     = dtpid_pkg::SPD_W;
    localparam int POS_W     = dtpid_pkg::POS_W;
    localparam int POWER_W   = dtpid_pkg::POWER_W;
    localparam int GAIN_W    = dtpid_pkg::GAIN_W;
    localparam int CFG_IDX_W = dtpid_pkg::CFG_IDX_W;

    localparam logic [MODE_W-1:0] MODE_TICK  = dtpid_pkg::MODE_TICK;
    localparam logic [MODE_W-1:0] MODE_DRIVE = dtpid_pkg::MODE_DRIVE;
    localparam logic [MODE_W-1:0] MODE_TURN  = dtpid_pkg::MODE_TURN;

    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_KP = dtpid_pkg::REG_DRIVE_KP;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_KI = dtpid_pkg::REG_DRIVE_KI;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_KD = dtpid_pkg::REG_DRIVE_KD;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_KP  = dtpid_pkg::REG_TURN_KP;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_KI  = dtpid_pkg::REG_TURN_KI;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_KD  = dtpid_pkg::REG_TURN_KD;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_KP  = dtpid_pkg::REG_HOLD_KP;

    localparam logic [GAIN_W-1:0] DRIVE_KP_RST = dtpid_pkg::DRIVE_KP_RST;
    localparam logic [GAIN_W-1:0] DRIVE_KI_RST = dtpid_pkg::DRIVE_KI_RST;
    localparam logic [GAIN_W-1:0] DRIVE_KD_RST = dtpid_pkg::DRIVE_KD_RST;
    localparam logic [GAIN_W-1:0] TURN_KP_RST  = dtpid_pkg::TURN_KP_RST;
    localparam logic [GAIN_W-1:0] TURN_KI_RST  = dtpid_pkg::TURN_KI_RST;
    localparam logic [GAIN_W-1:0] TURN_KD_RST  = dtpid_pkg::TURN_KD_RST;
    localparam logic [GAIN_W-1:0] HOLD_KP_RST  = dtpid_pkg::HOLD_KP_RST;

    localparam int COUNTS_PER_UNIT = dtpid_pkg::COUNTS_PER_UNIT;
    localparam int DRIVE_TOL       = dtpid_pkg::DRIVE_TOL;
    localparam int TURN_TOL        = dtpid_pkg::TURN_TOL;
    localparam int POWER_MAX       = dtpid_pkg::POWER_MAX;

    localparam int DRIVE_INTEGRAL_LIMIT_DEF = dtpid_pkg::DRIVE_INTEGRAL_LIMIT_DEF;
    localparam int TURN_INTEGRAL_MAX_DEF    = dtpid_pkg::TURN_INTEGRAL_MAX_DEF;
    localparam int TURN_INTEGRAL_MIN_DEF    = dtpid_pkg::TURN_INTEGRAL_MIN_DEF;

    typedef dtpid_pkg::in_item_t  in_item_t;
    typedef dtpid_pkg::out_item_t out_item_t;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 4;
    localparam int DRAIN_CYCLES = 16;     // longest command-to-result latency plus margin
    localparam int TAIL_CYCLES  = 24;
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 130;
    localparam int NOISE_PCT    = 20;

    localparam logic [CFG_IDX_W-1:0] GAIN_REGS [7] = '{
        REG_DRIVE_KP, REG_DRIVE_KI, REG_DRIVE_KD,
        REG_TURN_KP, REG_TURN_KI, REG_TURN_KD, REG_HOLD_KP
    };
    localparam logic [GAIN_W-1:0] GAIN_DEFAULTS [7] = '{
        DRIVE_KP_RST, DRIVE_KI_RST, DRIVE_KD_RST,
        TURN_KP_RST, TURN_KI_RST, TURN_KD_RST, HOLD_KP_RST
    };

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

    typedef struct {
        in_item_t  cmd;
        bit        typed;
        out_item_t want;
    } table_row_t;

    logic clk;
    logic rst_n;
    logic                 cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0]    cfg_wdata;

    dtpid_cmd_if cmd_ch ();
    dtpid_res_if res_ch ();

    drive_turn_pid_controller_core #(
        .DRIVE_INTEGRAL_LIMIT (DRIVE_INTEGRAL_LIMIT_DEF),
        .TURN_INTEGRAL_MAX    (TURN_INTEGRAL_MAX_DEF),
        .TURN_INTEGRAL_MIN    (TURN_INTEGRAL_MIN_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .result    (res_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Controller model state, mirrored in the testbench
    logic [GAIN_W-1:0]        gain_q88 [7];
    bit                       drv_active;
    bit                       trn_active;
    logic signed [GOAL_W-1:0] tgt_goal;
    logic [SPD_W-1:0]         pwr_cap;
    logic signed [11:0]       drv_integ;
    logic [9:0]               trn_integ;
    logic signed [31:0]       drv_last_err;
    logic signed [24:0]       trn_last_err;
    logic signed [POS_W-1:0]  head_ref;

    out_item_t  pending_motor_q [$];
    table_row_t dir_table [$];

    // Bookkeeping
    int        err_count     = 0;
    int        results_seen  = 0;
    int        moves_seen    = 0;
    int        cmds_sent     = 0;
    int        live_items    = 0;
    int        hold_req_cnt  = 0;
    int        hold_done_cnt = 0;
    bit        gaps_on       = 1'b0;
    int        burst_left    = 0;
    rx_style_t rx_style      = RX_ALWAYS;

    // Clock
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    function automatic longint clamp_l(input longint v, input longint lo, input longint hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Q8.8 to integer, halves rounded towards +infinity
    function automatic longint round_q88(input longint x);
        return (x + 128) >>> 8;
    endfunction

    function automatic longint rand_between(input longint lo, input longint hi);
        return longint'($urandom_range(0, int'(hi - lo))) + lo;
    endfunction

    function automatic logic signed [POS_W-1:0] to_pos(input longint v);
        longint lim;
        lim = longint'(1) <<< (POS_W - 1);
        return POS_W'(clamp_l(v, -lim, lim - 1));
    endfunction

    // Expected motor command for one accepted transaction; advances the mirrored state
    function automatic out_item_t predict_motor_cmd(input in_item_t c);
        out_item_t r;
        longint sum, avg, err, der, pid, corr, acc, lp, rp, cap;
        bit finished;
        r = '0;
        lp = 0;
        rp = 0;
        finished = 1'b0;
        cap = longint'(pwr_cap);
        if (c.mode == MODE_DRIVE || c.mode == MODE_TURN)
        begin
            tgt_goal   = c.goal;
            pwr_cap    = (c.speed_limit > POWER_MAX) ? SPD_W'(POWER_MAX) : c.speed_limit;
            drv_active = (c.mode == MODE_DRIVE);
            trn_active = (c.mode == MODE_TURN);
        end
        else if (c.mode == MODE_TICK && drv_active)
        begin
            sum = longint'($signed(c.left_position)) + longint'($signed(c.right_position));
            avg = sum >>> 1;
            err = longint'(tgt_goal) * COUNTS_PER_UNIT - avg;
            der = err - longint'(drv_last_err);
            drv_integ = 12'(clamp_l(longint'(drv_integ) + err,
                                    -DRIVE_INTEGRAL_LIMIT_DEF, DRIVE_INTEGRAL_LIMIT_DEF));
            pid = round_q88(longint'(gain_q88[REG_DRIVE_KP]) * err
                            + longint'(gain_q88[REG_DRIVE_KI]) * longint'(drv_integ)
                            + longint'(gain_q88[REG_DRIVE_KD]) * der);
            pid = clamp_l(pid, -cap, cap);
            drv_last_err = 32'(err);
            corr = round_q88(longint'(gain_q88[REG_HOLD_KP])
                             * (longint'($signed(c.heading)) - longint'(head_ref)));
            lp = clamp_l(pid - corr, -POWER_MAX, POWER_MAX);
            rp = clamp_l(pid + corr, -POWER_MAX, POWER_MAX);
            finished = (err <= DRIVE_TOL && err >= -DRIVE_TOL);
        end
        else if (c.mode == MODE_TICK && trn_active)
        begin
            err = longint'(tgt_goal) - longint'($signed(c.heading));
            der = err - longint'(trn_last_err);
            acc = longint'(trn_integ) + err;
            // upper bound is tested first
            if (acc >= TURN_INTEGRAL_MAX_DEF)
                acc = TURN_INTEGRAL_MAX_DEF;
            else if (acc <= TURN_INTEGRAL_MIN_DEF)
                acc = TURN_INTEGRAL_MIN_DEF;
            trn_integ = 10'(acc);
            pid = round_q88(longint'(gain_q88[REG_TURN_KP]) * err
                            + longint'(gain_q88[REG_TURN_KI]) * acc
                            + longint'(gain_q88[REG_TURN_KD]) * der);
            pid = clamp_l(pid, -cap, cap);
            trn_last_err = 25'(err);
            lp = clamp_l(pid, -POWER_MAX, POWER_MAX);
            rp = clamp_l(-pid, -POWER_MAX, POWER_MAX);
            finished = (err <= TURN_TOL && err >= -TURN_TOL);
            if (finished)
                head_ref = POS_W'(longint'(tgt_goal));
        end
        // completion clears the move, integrals and previous errors
        if (finished)
        begin
            drv_active   = 1'b0;
            trn_active   = 1'b0;
            tgt_goal     = '0;
            pwr_cap      = '0;
            drv_integ    = '0;
            trn_integ    = '0;
            drv_last_err = '0;
            trn_last_err = '0;
        end
        r.left_power    = POWER_W'(lp);
        r.right_power   = POWER_W'(rp);
        r.driving       = drv_active;
        r.turning       = trn_active;
        r.zero_encoders = finished;
        r.move_done     = finished;
        return r;
    endfunction

    function automatic in_item_t mk_cmd(input logic [MODE_W-1:0] m, input int goal,
                                        input int spd, input int l, input int r, input int h);
        in_item_t c;
        c.mode           = m;
        c.goal           = GOAL_W'(goal);
        c.speed_limit    = SPD_W'(spd);
        c.left_position  = POS_W'(l);
        c.right_position = POS_W'(r);
        c.heading        = POS_W'(h);
        return c;
    endfunction

    // Result with the motors off and no completion
    function automatic out_item_t idle_res(input bit d, input bit t);
        out_item_t r;
        r = '0;
        r.driving = d;
        r.turning = t;
        return r;
    endfunction

    task automatic add_row(input in_item_t c, input bit typed, input out_item_t want);
        table_row_t row;
        row.cmd   = c;
        row.typed = typed;
        row.want  = want;
        dir_table.push_back(row);
    endtask

    // Offer one command transaction; called and returns at a falling edge
    task automatic send_cmd(input in_item_t c, input bit typed, input out_item_t want);
        out_item_t predicted;
        int unsigned gap;
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        predicted = predict_motor_cmd(c);
        pending_motor_q.push_back(typed ? want : predicted);
        cmds_sent++;
        @(negedge clk);
        // bursts of random length separated by random gaps
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 6);
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
                burst_left = $urandom_range(1, 12);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // Sender pauses until every expected result has arrived
    task automatic wait_results_drained();
        cmd_ch.valid <= 1'b0;
        while (pending_motor_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write every gain register; block must be idle
    task automatic load_gains(input logic [GAIN_W-1:0] g [7]);
        for (int i = 0; i < 7; i++)
        begin
            cfg_wen   <= 1'b1;
            cfg_index <= GAIN_REGS[i];
            cfg_wdata <= g[i];
            gain_q88[GAIN_REGS[i]] = g[i];
            @(negedge clk);
        end
        cfg_wen <= 1'b0;
    endtask

    // One start command followed by ticks that close in on the goal
    task automatic run_move();
        in_item_t c;
        bit turn_move;
        longint goal, target, origin, v, skew;
        int steps;
        turn_move = $urandom_range(0, 1);
        if ($urandom_range(0, 9) == 0)
            goal = longint'($signed(16'($urandom)));
        else if (turn_move)
            goal = rand_between(-720, 720);
        else
            goal = rand_between(-20, 20);
        c.mode           = turn_move ? MODE_TURN : MODE_DRIVE;
        c.goal           = GOAL_W'(goal);
        c.speed_limit    = ($urandom_range(0, 9) == 0) ? SPD_W'($urandom)
                                                       : SPD_W'($urandom_range(20, 100));
        c.left_position  = POS_W'($urandom);
        c.right_position = POS_W'($urandom);
        c.heading        = POS_W'($urandom);
        send_cmd(c, 1'b0, '0);
        live_items++;

        target = turn_move ? longint'(c.goal) : longint'(c.goal) * COUNTS_PER_UNIT;
        origin = turn_move ? longint'(head_ref) + rand_between(-30, 30) : rand_between(-40, 40);
        steps  = $urandom_range(1, 8);
        for (int k = 1; k <= steps; k++)
        begin
            v = origin + (target - origin) * k / steps;
            if (k == steps)
                v += turn_move ? rand_between(-7, 7) : rand_between(-14, 14);
            else
                v += rand_between(-60, 60);
            c.mode = MODE_TICK;
            if (turn_move)
            begin
                c.heading        = to_pos(v);
                c.left_position  = to_pos(rand_between(-2000, 2000));
                c.right_position = to_pos(rand_between(-2000, 2000));
            end
            else
            begin
                skew = rand_between(-300, 300);
                c.left_position  = to_pos(v + skew);
                c.right_position = to_pos(v - skew + longint'($urandom_range(0, 1)));
                c.heading        = to_pos(longint'(head_ref) + rand_between(-25, 25));
            end
            send_cmd(c, 1'b0, '0);
            live_items++;
            // finished, or an abandoned sequence
            if (!(drv_active || trn_active) || $urandom_range(0, 19) == 0)
                break;
        end
    endtask

    // Random stimulus: mostly whole moves, the rest raw noise
    task automatic run_phase(input int n_items);
        in_item_t c;
        int stop_at;
        int half_at;
        stop_at = live_items + n_items;
        half_at = live_items + n_items / 2;
        while (live_items < stop_at)
        begin
            if ($urandom_range(0, 99) < NOISE_PCT)
            begin
                c.mode           = MODE_W'($urandom);
                c.goal           = GOAL_W'($urandom);
                c.speed_limit    = SPD_W'($urandom);
                c.left_position  = POS_W'($urandom);
                c.right_position = POS_W'($urandom);
                c.heading        = POS_W'($urandom);
                if (c.mode == MODE_DRIVE || c.mode == MODE_TURN
                    || (c.mode == MODE_TICK && (drv_active || trn_active)))
                    live_items++;
                send_cmd(c, 1'b0, '0);
            end
            else
            begin
                run_move();
            end
            if (half_at > 0 && live_items >= half_at)
            begin
                wait_results_drained();
                half_at = 0;
            end
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // Result receiver: own stall pattern plus requested long hold-offs
    initial
    begin : result_sink
        int unsigned tick_cnt;
        res_ch.ready = 1'b0;
        tick_cnt = 0;
        forever
        begin
            @(negedge clk);
            tick_cnt++;
            if (hold_req_cnt != hold_done_cnt)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done_cnt++;
            end
            case (rx_style)
                RX_ALWAYS:
                    res_ch.ready <= 1'b1;
                RX_PATTERN:
                    res_ch.ready <= ((tick_cnt % 7) < 4);
                default:
                begin
                    if ($urandom_range(0, 99) < 4)
                    begin
                        res_ch.ready <= 1'b0;
                        repeat ($urandom_range(4, 12)) @(negedge clk);
                    end
                    else
                    begin
                        res_ch.ready <= ($urandom_range(0, 99) >= 30);
                    end
                end
            endcase
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            results_seen++;
            if (pending_motor_q.size() == 0)
            begin
                $error("result transaction with no command outstanding");
                err_count++;
            end
            else
            begin
                want = pending_motor_q.pop_front();
                check_field("left_power", longint'($signed(want.left_power)),
                            longint'($signed(res_ch.data.left_power)));
                check_field("right_power", longint'($signed(want.right_power)),
                            longint'($signed(res_ch.data.right_power)));
                check_field("driving", longint'(want.driving), longint'(res_ch.data.driving));
                check_field("turning", longint'(want.turning), longint'(res_ch.data.turning));
                check_field("zero_encoders", longint'(want.zero_encoders),
                            longint'(res_ch.data.zero_encoders));
                check_field("move_done", longint'(want.move_done),
                            longint'(res_ch.data.move_done));
                if (res_ch.data.move_done === 1'b1)
                    moves_seen++;
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, pending_motor_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Main stimulus
    initial
    begin : stimulus
        logic [GAIN_W-1:0] g [7];
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        cfg_wen      = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        rst_n        = 1'b0;

        // mirrored state after reset
        for (int i = 0; i < 7; i++)
            gain_q88[GAIN_REGS[i]] = GAIN_DEFAULTS[i];
        drv_active   = 1'b0;
        trn_active   = 1'b0;
        tgt_goal     = '0;
        pwr_cap      = '0;
        drv_integ    = '0;
        trn_integ    = '0;
        drv_last_err = '0;
        trn_last_err = '0;
        head_ref     = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table, default gains
        // idle tick, then unused mode code with extreme fields
        add_row(mk_cmd(MODE_TICK, 0, 0, 0, 0, 0), 1'b1, idle_res(0, 0));
        add_row(mk_cmd(MODE_UNUSED, -32768, 127, -8388608, 8388607, -8388608),
                1'b1, idle_res(0, 0));
        // short drive completing inside tolerance
        add_row(mk_cmd(MODE_DRIVE, 1, 50, 0, 0, 0), 1'b1, idle_res(1, 0));
        add_row(mk_cmd(MODE_UNUSED, 5, 5, 5, 5, 5), 1'b1, idle_res(1, 0));
        add_row(mk_cmd(MODE_TICK, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_cmd(MODE_TICK, 0, 0, 800, 831, 0), 1'b0, '0);
        add_row(mk_cmd(MODE_TICK, 0, 0, 100, 100, 100), 1'b1, idle_res(0, 0));
        // speed limit above 100 saturates; a start overrides the other mode
        add_row(mk_cmd(MODE_TURN, 90, 127, 0, 0, 0), 1'b1, idle_res(0, 1));
        add_row(mk_cmd(MODE_DRIVE, 2, 30, 0, 0, 0), 1'b1, idle_res(1, 0));
        add_row(mk_cmd(MODE_TURN, 90, 127, 0, 0, 0), 1'b1, idle_res(0, 1));
        add_row(mk_cmd(MODE_TICK, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_cmd(MODE_TICK, 0, 0, 0, 0, 84), 1'b0, '0);
        add_row(mk_cmd(MODE_TICK, 0, 0, 0, 0, 95), 1'b0, '0);
        // extreme goal and encoder readings, power saturation
        add_row(mk_cmd(MODE_DRIVE, 32767, 100, 0, 0, 0), 1'b1, idle_res(1, 0));
        add_row(mk_cmd(MODE_TICK, 0, 0, -8388608, -8388608, 8388607), 1'b0, '0);
        add_row(mk_cmd(MODE_TICK, 0, 0, 8388607, 8388607, -8388608), 1'b0, '0);
        // zero power limit leaves only the heading correction
        add_row(mk_cmd(MODE_DRIVE, -32768, 0, 0, 0, 0), 1'b1, idle_res(1, 0));
        add_row(mk_cmd(MODE_TICK, 0, 0, 0, 0, 300), 1'b0, '0);
        // turn to the most negative goal, then reference update
        add_row(mk_cmd(MODE_TURN, -32768, 100, 0, 0, 0), 1'b1, idle_res(0, 1));
        add_row(mk_cmd(MODE_TICK, 0, 0, 0, 0, 8388607), 1'b0, '0);
        add_row(mk_cmd(MODE_TICK, 0, 0, 0, 0, -32763), 1'b0, '0);
        // drive tolerance edges, odd negative encoder sum
        add_row(mk_cmd(MODE_DRIVE, 0, 100, 0, 0, 0), 1'b1, idle_res(1, 0));
        add_row(mk_cmd(MODE_TICK, 0, 0, -11, -10, -32768), 1'b0, '0);
        add_row(mk_cmd(MODE_TICK, 0, 0, 10, 11, -32768), 1'b0, '0);
        add_row(mk_cmd(MODE_UNUSED, 0, 0, 0, 0, 0), 1'b1, idle_res(0, 0));

        gaps_on  = 1'b1;
        rx_style = RX_RANDOM;
        foreach (dir_table[i])
            send_cmd(dir_table[i].cmd, dir_table[i].typed, dir_table[i].want);

        // Random phases, each under its own gain setting
        for (int ph = 0; ph < 5; ph++)
        begin
            wait_results_drained();
            for (int i = 0; i < 7; i++)
            begin
                case (ph)
                    0: g[i] = GAIN_W'($urandom_range(0, 400));
                    1: g[i] = '0;
                    2: g[i] = '1;
                    3: g[i] = GAIN_W'($urandom);
                    default: g[i] = GAIN_DEFAULTS[i];
                endcase
            end
            load_gains(g);
            case (ph)
                0:
                begin
                    gaps_on  = 1'b1;
                    rx_style = RX_RANDOM;
                end
                1:
                begin
                    gaps_on  = 1'b0;
                    rx_style = RX_ALWAYS;
                    hold_req_cnt++;
                end
                2:
                begin
                    gaps_on  = 1'b1;
                    rx_style = RX_PATTERN;
                end
                3:
                begin
                    gaps_on  = 1'b0;
                    rx_style = RX_RANDOM;
                    hold_req_cnt++;
                end
                default:
                begin
                    gaps_on  = 1'b1;
                    rx_style = RX_RANDOM;
                end
            endcase
            run_phase(PHASE_ITEMS);
        end

        // Drain and settle
        cmd_ch.valid <= 1'b0;
        while (pending_motor_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Coverage: %0d command transactions (%0d directed) under 6 gain settings",
                 cmds_sent, dir_table.size());
        $display("Coverage: %0d results checked, %0d moves completed, %0d long receiver holds",
                 results_seen, moves_seen, hold_done_cnt);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/dtpid_pkg.sv
rtl/dtpid_if.sv
rtl/dtpid_mac.sv
rtl/drive_turn_pid_controller_core.sv
verif/testbench.sv
